// File: hdl/dtrb_pkg.sv
package dtrb_pkg;

  // width of the shared subtractor and of the year
  localparam int unsigned WORD_W = 12;

  // 1 january of this year is a monday
  localparam logic [WORD_W-1:0] BASE_YEAR = 12'd1990;
  localparam logic [6:0]        BASE_M100 = 7'(BASE_YEAR % 12'd100);
  localparam logic [8:0]        BASE_M400 = 9'(BASE_YEAR % 12'd400);

  localparam logic [WORD_W-1:0] K400 = 12'd400;
  localparam logic [WORD_W-1:0] K100 = 12'd100;
  localparam logic [WORD_W-1:0] K10  = 12'd10;
  localparam logic [WORD_W-1:0] K7   = 12'd7;

  localparam logic [6:0] M100_LAST = 7'd99;
  localparam logic [8:0] M400_LAST = 9'd399;

  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;
  localparam logic [3:0] LAST_MONTH = 4'd12;
  localparam logic [3:0] FEB_IDX    = 4'd1;
  localparam logic [3:0] FEB        = 4'd2;

  // order in which the bcd images are produced
  localparam logic [2:0] BCD_SECOND = 3'd0;
  localparam logic [2:0] BCD_MINUTE = 3'd1;
  localparam logic [2:0] BCD_HOUR   = 3'd2;
  localparam logic [2:0] BCD_DAY    = 3'd3;
  localparam logic [2:0] BCD_MONTH  = 3'd4;
  localparam logic [2:0] BCD_YEAR   = 3'd5;
  localparam int unsigned BCD_N     = 6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD400,
    S_MOD100,
    S_YEAR,
    S_MONTH,
    S_DAY7,
    S_BCD,
    S_DONE
  } state_t;

  // month length modulo 7, zero-based month index
  function automatic logic [1:0] month_len_mod7(input logic [3:0] idx);
    logic [1:0] r;
    unique case (idx)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: r = 2'd3;
      4'd3, 4'd5, 4'd8, 4'd10:                   r = 2'd2;
      default:                                   r = 2'd0;
    endcase
    return r;
  endfunction

  // days in a month, one-based month number, zero for a month that does not exist
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] r;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = leap ? 5'd29 : 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [1:0] k);
    logic [3:0] s;
    s = {1'b0, a} + {2'b00, k};
    return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
  endfunction

endpackage

// File: hdl/dtrb_item_if.sv
interface dtrb_item_if;
  import dtrb_pkg::*;

  logic       valid;
  logic       ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source (
    output valid, year, month, day, hour, minute, second,
    input  ready
  );

  modport sink (
    input  valid, year, month, day, hour, minute, second,
    output ready
  );
endinterface

// File: hdl/dtrb_result_if.sv
interface dtrb_result_if;
  import dtrb_pkg::*;

  logic       valid;
  logic       ready;
  logic       date_valid;
  logic       time_valid;
  logic [7:0] second_bcd;
  logic [7:0] minute_bcd;
  logic [7:0] hour_bcd;
  logic [2:0] weekday;
  logic [7:0] day_bcd;
  logic [7:0] month_bcd;
  logic [7:0] year_bcd;

  modport source (
    output valid, date_valid, time_valid, second_bcd, minute_bcd, hour_bcd,
           weekday, day_bcd, month_bcd, year_bcd,
    input  ready
  );

  modport sink (
    input  valid, date_valid, time_valid, second_bcd, minute_bcd, hour_bcd,
           weekday, day_bcd, month_bcd, year_bcd,
    output ready
  );
endinterface

// File: hdl/dtrb_sub.sv
module dtrb_sub
  import dtrb_pkg::*;
(
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [WORD_W-1:0] diff,
  output logic              ge
);

  logic borrow;

  // one subtract and compare, shared by every reduction step
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};
  assign ge = ~borrow;

endmodule

// File: hdl/date_time_to_rtc_bcd.sv
// channel  dir  modport  payload
// item     in   sink     year[11:0] month[3:0] day[4:0] hour[4:0] minute[5:0] second[5:0]
// result   out  source   date_valid time_valid second/minute/hour_bcd weekday day/month/year_bcd
//
// one item at a time; item.ready is high only when the sequencer is idle
// per item the sequencer runs a mod-400 reduction, a mod-100 reduction, a walk over the
//   years from 1990 up to the effective year, a walk over the months before the given one,
//   a mod-7 reduction, 6 bcd digits by repeated subtraction of ten and the hand-over;
//   the year walk dominates
// the result sits in an output register, so a new item is taken while it waits;
//   a stalled result only holds the sequencer at its last step
// rst is synchronous and clears the sequencer and the result valid, no clearing pass
module date_time_to_rtc_bcd
  import dtrb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  dtrb_item_if.sink     item,
  dtrb_result_if.source result
);

  // control
  state_t state, state_next;
  logic   out_valid, out_valid_next;

  // captured item
  logic [11:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [5:0]  second_r;

  // working registers
  logic [WORD_W-1:0] rem, rem_next;
  logic              z400, z400_next;
  logic [6:0]        r100, r100_next;
  logic              leap_raw, leap_raw_next;
  logic [11:0]       y_cnt, y_cnt_next;
  logic [6:0]        m100, m100_next;
  logic [8:0]        m400, m400_next;
  logic [2:0]        acc, acc_next;
  logic              ey_leap, ey_leap_next;
  logic [3:0]        mcnt, mcnt_next;
  logic [3:0]        mlim, mlim_next;
  logic [2:0]        wday, wday_next;
  logic [2:0]        bidx, bidx_next;
  logic [3:0]        tens, tens_next;
  logic [7:0]        bcd [BCD_N];
  logic              bcd_we;

  // result register
  logic       o_date_valid, o_time_valid;
  logic [7:0] o_second, o_minute, o_hour, o_day, o_month, o_year;
  logic [2:0] o_weekday;
  logic       load_out;

  // shared subtractor
  logic [WORD_W-1:0] sub_b, sub_diff;
  logic              sub_ge;

  logic        accept;
  logic [11:0] ey;
  logic        y_leap;
  logic [6:0]  bcd_src;
  logic        date_ok, time_ok;
  logic [2:0]  bidx_inc;

  dtrb_sub u_sub (
    .a    (rem),
    .b    (sub_b),
    .diff (sub_diff),
    .ge   (sub_ge)
  );

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid & item.ready;

  // years before the base count as the base year
  assign ey     = (year_r < BASE_YEAR) ? BASE_YEAR : year_r;
  assign y_leap = ((y_cnt[1:0] == 2'b00) && (m100 != 7'd0)) || (m400 == 9'd0);

  assign bidx_inc = bidx + 3'd1;

  // value to split into tens and units for the next bcd image
  always_comb begin
    unique case (bidx_inc)
      BCD_MINUTE: bcd_src = {1'b0, minute_r};
      BCD_HOUR:   bcd_src = {2'b00, hour_r};
      BCD_DAY:    bcd_src = {2'b00, day_r};
      BCD_MONTH:  bcd_src = {3'b000, month_r};
      BCD_YEAR:   bcd_src = r100;
      default:    bcd_src = {1'b0, second_r};
    endcase
  end

  always_comb begin
    unique case (state)
      S_MOD400: sub_b = K400;
      S_MOD100: sub_b = K100;
      S_DAY7:   sub_b = K7;
      S_BCD:    sub_b = K10;
      default:  sub_b = '0;
    endcase
  end

  assign date_ok = (month_r >= 4'd1) && (month_r <= LAST_MONTH) && (day_r != 5'd0) &&
                   (day_r <= month_days(month_r, leap_raw));
  assign time_ok = (hour_r <= HOUR_MAX) && (minute_r <= MINSEC_MAX) &&
                   (second_r <= MINSEC_MAX);

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    rem_next       = rem;
    z400_next      = z400;
    r100_next      = r100;
    leap_raw_next  = leap_raw;
    y_cnt_next     = y_cnt;
    m100_next      = m100;
    m400_next      = m400;
    acc_next       = acc;
    ey_leap_next   = ey_leap;
    mcnt_next      = mcnt;
    mlim_next      = mlim;
    wday_next      = wday;
    bidx_next      = bidx;
    tens_next      = tens;
    bcd_we         = 1'b0;
    load_out       = 1'b0;

    if (out_valid && result.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          rem_next   = item.year;
          state_next = S_MOD400;
        end
      end
      // year modulo 400
      S_MOD400: begin
        if (sub_ge) begin
          rem_next = sub_diff;
        end else begin
          z400_next  = (rem == '0);
          state_next = S_MOD100;
        end
      end
      // year modulo 100, then leap flag of the raw year
      S_MOD100: begin
        if (sub_ge) begin
          rem_next = sub_diff;
        end else begin
          r100_next     = rem[6:0];
          leap_raw_next = ((year_r[1:0] == 2'b00) && (rem != '0)) || z400;
          y_cnt_next    = BASE_YEAR;
          m100_next     = BASE_M100;
          m400_next     = BASE_M400;
          acc_next      = 3'd0;
          state_next    = S_YEAR;
        end
      end
      // one year per cycle, 365 or 366 days reduced mod 7 to 1 or 2
      S_YEAR: begin
        if (y_cnt == ey) begin
          ey_leap_next = y_leap;
          mcnt_next    = 4'd0;
          if (month_r == 4'd0) begin
            mlim_next = 4'd0;
          end else if (month_r > LAST_MONTH) begin
            mlim_next = LAST_MONTH;
          end else begin
            mlim_next = month_r - 4'd1;
          end
          state_next = S_MONTH;
        end else begin
          acc_next   = add_mod7(acc, y_leap ? 2'd2 : 2'd1);
          y_cnt_next = y_cnt + 12'd1;
          m100_next  = (m100 == M100_LAST) ? 7'd0 : m100 + 7'd1;
          m400_next  = (m400 == M400_LAST) ? 9'd0 : m400 + 9'd1;
        end
      end
      // one month per cycle, february gains a day in a leap year
      S_MONTH: begin
        if (mcnt == mlim) begin
          rem_next   = WORD_W'(acc) + WORD_W'(day_r);
          state_next = S_DAY7;
        end else begin
          acc_next  = add_mod7(acc, month_len_mod7(mcnt) +
                               {1'b0, (mcnt == FEB_IDX) && ey_leap});
          mcnt_next = mcnt + 4'd1;
        end
      end
      // add the day and reduce mod 7, zero means sunday
      S_DAY7: begin
        if (sub_ge) begin
          rem_next = sub_diff;
        end else begin
          wday_next  = (rem[2:0] == 3'd0) ? 3'd7 : rem[2:0];
          bidx_next  = BCD_SECOND;
          rem_next   = WORD_W'(second_r);
          tens_next  = 4'd0;
          state_next = S_BCD;
        end
      end
      // tens by repeated subtraction of ten
      S_BCD: begin
        if (sub_ge) begin
          rem_next  = sub_diff;
          tens_next = tens + 4'd1;
        end else begin
          bcd_we = 1'b1;
          if (bidx == BCD_YEAR) begin
            state_next = S_DONE;
          end else begin
            bidx_next = bidx_inc;
            rem_next  = WORD_W'(bcd_src);
            tens_next = 4'd0;
          end
        end
      end
      // hand over once the result register is free
      S_DONE: begin
        if (!out_valid || result.ready) begin
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      year_r   <= item.year;
      month_r  <= item.month;
      day_r    <= item.day;
      hour_r   <= item.hour;
      minute_r <= item.minute;
      second_r <= item.second;
    end
    rem      <= rem_next;
    z400     <= z400_next;
    r100     <= r100_next;
    leap_raw <= leap_raw_next;
    y_cnt    <= y_cnt_next;
    m100     <= m100_next;
    m400     <= m400_next;
    acc      <= acc_next;
    ey_leap  <= ey_leap_next;
    mcnt     <= mcnt_next;
    mlim     <= mlim_next;
    wday     <= wday_next;
    bidx     <= bidx_next;
    tens     <= tens_next;
    if (bcd_we) begin
      bcd[bidx] <= {tens, rem[3:0]};
    end
    if (load_out) begin
      o_date_valid <= date_ok;
      o_time_valid <= time_ok;
      o_second     <= bcd[BCD_SECOND];
      o_minute     <= bcd[BCD_MINUTE];
      o_hour       <= bcd[BCD_HOUR];
      o_day        <= bcd[BCD_DAY];
      o_month      <= bcd[BCD_MONTH];
      o_year       <= bcd[BCD_YEAR];
      o_weekday    <= wday;
    end
  end

  assign result.valid      = out_valid;
  assign result.date_valid = o_date_valid;
  assign result.time_valid = o_time_valid;
  assign result.second_bcd = o_second;
  assign result.minute_bcd = o_minute;
  assign result.hour_bcd   = o_hour;
  assign result.weekday    = o_weekday;
  assign result.day_bcd    = o_day;
  assign result.month_bcd  = o_month;
  assign result.year_bcd   = o_year;

  // a taken item keeps the sequencer busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !item.ready)
    else $error("item accepted while sequencer still idle");

  // the year walk never passes its target
  a_year_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_YEAR) |-> (y_cnt <= ey))
    else $error("year walk overran target");

  // the leap counters stay in range and in step with each other while walking
  a_leap_counters: assert property (@(posedge clk) disable iff (rst)
    (state == S_YEAR) |-> ((m100 <= M100_LAST) && (m400 <= M400_LAST) &&
                           (m400 % 9'd100 == 9'(m100))))
    else $error("leap counters out of step");

  // digit extraction only sees values below one hundred
  a_bcd_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_BCD) |-> ((rem < K100) && (tens <= 4'd9)))
    else $error("bcd operand out of range");

  // a new result always carries a weekday from monday to sunday
  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (o_weekday != 3'd0))
    else $error("weekday zero on result");

endmodule
